// ===== src/shirr_pkg.sv =====
`timescale 1ns / 1ps
package shirr_pkg;

  localparam int unsigned ACC_W     = 48;
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned NUM_BASIS = 9;
  localparam int unsigned BASIS_W   = $clog2(NUM_BASIS);
  localparam int unsigned ROW_W     = NUM_CH * ACC_W;
  localparam int unsigned F_W       = 20;
  localparam int unsigned P_W       = 62;
  localparam int unsigned SUM_W     = 56;
  localparam int unsigned WIDE_W    = 66;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_EVAL  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef logic [BASIS_W-1:0] basis_t;

  function automatic logic [16:0] basis_k(input basis_t b, input logic eval);
    logic [16:0] k;
    unique case (b)
      4'd0:                k = eval ? 17'd58080 : 17'd18487;
      4'd1, 4'd2, 4'd3:    k = eval ? 17'd67064 : 17'd32021;
      4'd4, 4'd5, 4'd7:    k = eval ? 17'd56236 : 17'd71601;
      4'd6:                k = eval ? 17'd48701 : 17'd62010;
      4'd8:                k = eval ? 17'd28118 : 17'd35801;
      default:             k = 17'd0;
    endcase
    return k;
  endfunction

  function automatic logic [14:0] basis_d(input basis_t b, input logic eval);
    logic [14:0] d;
    if (b == 4'd6) begin
      d = eval ? 15'd16234 : 15'd20670;
    end else begin
      d = 15'd0;
    end
    return d;
  endfunction

endpackage

// ===== src/shirr_if.sv =====
`timescale 1ns / 1ps
interface shirr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] dir_x;
  logic [15:0] dir_y;
  logic [15:0] dir_z;
  logic [7:0]  pixel_red;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_blue;
  logic [31:0] sample_weight;

  modport source (output valid, opcode, dir_x, dir_y, dir_z, pixel_red, pixel_green,
                  pixel_blue, sample_weight, input ready);
  modport sink (input valid, opcode, dir_x, dir_y, dir_z, pixel_red, pixel_green,
                pixel_blue, sample_weight, output ready);
endinterface

interface shirr_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] irr_red;
  logic [23:0] irr_green;
  logic [23:0] irr_blue;

  modport source (output valid, irr_red, irr_green, irr_blue, input ready);
  modport sink (input valid, irr_red, irr_green, irr_blue, output ready);
endinterface

// ===== src/shirr_ram.sv =====
`timescale 1ns / 1ps
module shirr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/sh_irradiance_project_and_eval.sv =====
`timescale 1ns / 1ps
// An evaluate result is valid after the nine basis steps, a four-stage read-multiply-write
// drain on the coefficient RAM and the output load.
// A new item is taken only once the previous one has finished; clear and opcode 3 finish as taken.
// An evaluate result sits in an output register; the next item is taken meanwhile, and a
// later evaluate holds in its final cycle until that register frees.
// Reset (asynchronous, active low) marks all coefficient rows zero and empties the pipeline.
module sh_irradiance_project_and_eval import shirr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  shirr_in_if.sink    req_i,
  shirr_out_if.source res_o
);

  state_e state_q, state_d;
  basis_t cnt_q, cnt_d;
  logic   eval_q;
  logic signed [15:0] dx_q, dy_q, dz_q;
  logic [7:0]  pix_q [NUM_CH];
  logic [31:0] wgt_q;

  logic accept, start, clr, issue, last4, out_free, load_out;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign start       = accept && (req_i.opcode == OP_ACCUM || req_i.opcode == OP_EVAL);
  assign clr         = accept && (req_i.opcode == OP_CLEAR);
  assign out_free    = !res_o.valid || res_o.ready;

  logic v1_q, v2_q, v3_q, v4_q;
  basis_t b1_q, b2_q, b3_q, b4_q;
  assign last4 = v4_q && (b4_q == basis_t'(NUM_BASIS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_ISSUE;
      ST_ISSUE: if (cnt_q == basis_t'(NUM_BASIS - 1)) state_d = ST_DRAIN;
      ST_DRAIN: if (last4) state_d = eval_q ? ST_DONE : ST_IDLE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    issue    = (state_q == ST_ISSUE);
    load_out = (state_q == ST_DONE) && out_free;
    cnt_d    = cnt_q;
    if (issue) begin
      cnt_d = (cnt_q == basis_t'(NUM_BASIS - 1)) ? '0 : cnt_q + basis_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      eval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (start) eval_q <= (req_i.opcode == OP_EVAL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      dx_q     <= req_i.dir_x;
      dy_q     <= req_i.dir_y;
      dz_q     <= req_i.dir_z;
      pix_q[0] <= req_i.pixel_red;
      pix_q[1] <= req_i.pixel_green;
      pix_q[2] <= req_i.pixel_blue;
      wgt_q    <= req_i.sample_weight;
    end
  end

  // Stage 0: monomial of the basis.
  logic signed [16:0] opa, opb;
  logic signed [33:0] m_d, m1_q;
  always_comb begin
    unique case (cnt_q)
      4'd0:    begin opa = 17'sd16384;   opb = 17'sd16384;   end
      4'd1:    begin opa = 17'(dy_q);    opb = 17'sd16384;   end
      4'd2:    begin opa = 17'(dz_q);    opb = 17'sd16384;   end
      4'd3:    begin opa = 17'(dx_q);    opb = 17'sd16384;   end
      4'd4:    begin opa = 17'(dx_q);    opb = 17'(dy_q);    end
      4'd5:    begin opa = 17'(dy_q);    opb = 17'(dz_q);    end
      4'd6:    begin opa = 17'(dz_q);    opb = 17'(dz_q);    end
      4'd7:    begin opa = 17'(dx_q);    opb = 17'(dz_q);    end
      4'd8:    begin opa = 17'(dx_q) + 17'(dy_q); opb = 17'(dx_q) - 17'(dy_q); end
      default: begin opa = 17'sd0;       opb = 17'sd0;       end
    endcase
    m_d = opa * opb;
  end

  // Stage 1: factor, row read.
  logic signed [53:0] kprod, fsum;
  logic signed [F_W-1:0] f2_q, f3_q;
  logic [NUM_BASIS-1:0] row_vld_q;
  logic rvld2_q;
  always_comb begin
    kprod = $signed({1'b0, basis_k(b1_q, eval_q)}) * m1_q;
    fsum  = kprod - $signed({11'b0, basis_d(b1_q, eval_q), 28'b0}) + 54'sd134217728;
  end

  logic [ROW_W-1:0] rdata, wdata;
  logic we;

  shirr_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BASIS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (b4_q),
    .wdata_i (wdata),
    .re_i    (v1_q),
    .raddr_i (b1_q),
    .rdata_o (rdata)
  );

  // Stage 2..4 lanes.
  logic signed [ACC_W-1:0] coef2 [NUM_CH];
  logic signed [ACC_W-1:0] coef3_q [NUM_CH], coef4_q [NUM_CH];
  logic signed [31:0]      opnd_d [NUM_CH], opnd3_q [NUM_CH];
  logic signed [P_W-1:0]   p_d [NUM_CH], p4_q [NUM_CH];
  logic signed [SUM_W-1:0] sum_q [NUM_CH];
  logic signed [23:0]      irr_d [NUM_CH], irr_q [NUM_CH];

  always_comb begin
    logic signed [28:0]       pf;
    logic signed [WIDE_W-1:0] wide, sh;
    logic signed [32:0]       mb;
    logic signed [64:0]       prod;
    for (int c = 0; c < NUM_CH; c++) begin
      coef2[c] = rvld2_q ? $signed(rdata[c*ACC_W +: ACC_W]) : '0;
      pf = $signed({1'b0, pix_q[c]}) * f2_q;
      wide = WIDE_W'(coef2[c]) + WIDE_W'(33'sd32768);
      sh = wide >>> 16;
      if (sh > WIDE_W'(32'sh7fffffff)) opnd_d[c] = 32'sh7fffffff;
      else if (sh < -WIDE_W'(33'sh80000000)) opnd_d[c] = 32'sh80000000;
      else opnd_d[c] = sh[31:0];
      if (!eval_q) opnd_d[c] = 32'(pf);
      mb = eval_q ? 33'(f3_q) : $signed({1'b0, wgt_q});
      prod = opnd3_q[c] * mb;
      p_d[c] = prod[P_W-1:0];
    end
  end

  always_comb begin
    logic signed [WIDE_W-1:0] t, s, acc_max, acc_min, r;
    acc_max = (WIDE_W'(1) <<< (ACC_W - 1)) - WIDE_W'(1);
    acc_min = -acc_max - WIDE_W'(1);
    we = v4_q && !eval_q;
    for (int c = 0; c < NUM_CH; c++) begin
      t = (WIDE_W'(p4_q[c]) + WIDE_W'(33'sd32768)) >>> 16;
      s = WIDE_W'(coef4_q[c]) + t;
      if (s > acc_max) s = acc_max;
      else if (s < acc_min) s = acc_min;
      wdata[c*ACC_W +: ACC_W] = s[ACC_W-1:0];
      r = (WIDE_W'(sum_q[c]) + WIDE_W'(33'sd32768)) >>> 16;
      if (r > WIDE_W'(24'sh7fffff)) irr_d[c] = 24'sh7fffff;
      else if (r < -WIDE_W'(25'sh800000)) irr_d[c] = 24'sh800000;
      else irr_d[c] = r[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      rvld2_q   <= 1'b0;
      row_vld_q <= '0;
      res_o.valid <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (v1_q) rvld2_q <= row_vld_q[b1_q];
      if (clr) row_vld_q <= '0;
      else if (we) row_vld_q[b4_q] <= 1'b1;
      if (load_out) res_o.valid <= 1'b1;
      else if (res_o.ready) res_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q <= m_d;
    b1_q <= cnt_q;
    b2_q <= b1_q;
    b3_q <= b2_q;
    b4_q <= b3_q;
    f2_q <= fsum[28 +: F_W];
    f3_q <= f2_q;
    for (int c = 0; c < NUM_CH; c++) begin
      coef3_q[c] <= coef2[c];
      coef4_q[c] <= coef3_q[c];
      opnd3_q[c] <= opnd_d[c];
      p4_q[c]    <= p_d[c];
      if (start) sum_q[c] <= '0;
      else if (v4_q && eval_q) sum_q[c] <= sum_q[c] + p4_q[c][SUM_W-1:0];
      if (load_out) irr_q[c] <= irr_d[c];
    end
  end

  assign res_o.irr_red   = irr_q[0];
  assign res_o.irr_green = irr_q[1];
  assign res_o.irr_blue  = irr_q[2];

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> state_q == ST_DRAIN || state_q == ST_ISSUE)
    else $error("coefficient write outside an item");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(state_q == ST_DONE))
    else $error("result without evaluate");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last4 |=> state_q == ST_IDLE || state_q == ST_DONE)
    else $error("item did not finish after last basis");

  a_issue_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !v1_q && !v4_q)
    else $error("input taken with pipeline busy");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import shirr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 540;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [31:0]        w;
  } sample_t;

  typedef struct {
    logic [23:0] red;
    logic [23:0] green;
    logic [23:0] blue;
  } irr_t;

  typedef longint fvec_t [9];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  shirr_in_if  req_if ();
  shirr_out_if res_if ();

  sh_irradiance_project_and_eval DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .res_o (res_if.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 0;
  end

  longint coef_store [27];
  irr_t   irr_q [$];
  int     mismatches = 0;
  int     results_seen = 0;
  int     items_sent = 0;
  int     evals_sent = 0;
  bit     calm = 1'b0;
  int     hold_left = 0;

  function automatic longint rnd(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic fvec_t sh_factors(longint x, longint y, longint z, bit ev);
    fvec_t  f;
    longint c0, c1, cx, c6a, c6b, c8;
    c0  = ev ? 58080 : 18487;
    c1  = ev ? 67064 : 32021;
    cx  = ev ? 56236 : 71601;
    c6a = ev ? 48701 : 62010;
    c6b = ev ? 16234 : 20670;
    c8  = ev ? 28118 : 35801;
    f[0] = c0;
    f[1] = rnd(c1 * y, 14);
    f[2] = rnd(c1 * z, 14);
    f[3] = rnd(c1 * x, 14);
    f[4] = rnd(cx * (x * y), 28);
    f[5] = rnd(cx * (y * z), 28);
    f[6] = rnd(c6a * (z * z) - c6b * (longint'(1) <<< 28), 28);
    f[7] = rnd(cx * (x * z), 28);
    f[8] = rnd(c8 * (x * x - y * y), 28);
    return f;
  endfunction

  task automatic apply_sample(input sample_t s);
    fvec_t  f;
    longint pw [3];
    longint acc_max, acc_min, t, sum, l16;
    irr_t   e;
    longint ch [3];
    acc_max = (longint'(1) <<< (ACC_W - 1)) - 1;
    acc_min = -acc_max - 1;
    case (s.op)
      OP_CLEAR: begin
        foreach (coef_store[i]) coef_store[i] = 0;
      end
      OP_ACCUM: begin
        pw[0] = longint'(s.r) * longint'(s.w);
        pw[1] = longint'(s.g) * longint'(s.w);
        pw[2] = longint'(s.b) * longint'(s.w);
        f = sh_factors(longint'(s.x), longint'(s.y), longint'(s.z), 1'b0);
        for (int bi = 0; bi < 9; bi++) begin
          for (int c = 0; c < 3; c++) begin
            t = rnd(pw[c] * f[bi], 16);
            coef_store[bi*3+c] = clamp(coef_store[bi*3+c] + t, acc_min, acc_max);
          end
        end
      end
      OP_EVAL: begin
        f = sh_factors(longint'(s.x), longint'(s.y), longint'(s.z), 1'b1);
        for (int c = 0; c < 3; c++) begin
          sum = 0;
          for (int bi = 0; bi < 9; bi++) begin
            l16 = clamp(rnd(coef_store[bi*3+c], 16), -(longint'(1) <<< 31),
                        (longint'(1) <<< 31) - 1);
            sum += l16 * f[bi];
          end
          ch[c] = clamp(rnd(sum, 16), -8388608, 8388607);
        end
        e.red   = ch[0][23:0];
        e.green = ch[1][23:0];
        e.blue  = ch[2][23:0];
        irr_q.push_back(e);
        evals_sent++;
      end
      default: ;
    endcase
  endtask

  function automatic sample_t mk(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                                 logic [15:0] z, logic [7:0] r, logic [7:0] g,
                                 logic [7:0] b, logic [31:0] w);
    sample_t s;
    s.op = op; s.x = x; s.y = y; s.z = z;
    s.r = r; s.g = g; s.b = b; s.w = w;
    return s;
  endfunction

  task automatic send(input sample_t s);
    if (!calm && $urandom_range(99) < 18) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.opcode        <= s.op;
    req_if.dir_x         <= s.x;
    req_if.dir_y         <= s.y;
    req_if.dir_z         <= s.z;
    req_if.pixel_red     <= s.r;
    req_if.pixel_green   <= s.g;
    req_if.pixel_blue    <= s.b;
    req_if.sample_weight <= s.w;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    apply_sample(s);
    items_sent++;
  endtask

  // hold off on request, always ready when calm, otherwise random stalls
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= 18);
      end
    end
  end

  always @(posedge clk_i) begin
    irr_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (irr_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h %h %h", res_if.irr_red, res_if.irr_green,
                   res_if.irr_blue);
      end else begin
        e = irr_q.pop_front();
        if (e.red !== res_if.irr_red || e.green !== res_if.irr_green ||
            e.blue !== res_if.irr_blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("irradiance mismatch: expected %h %h %h, got %h %h %h",
                     e.red, e.green, e.blue, res_if.irr_red, res_if.irr_green,
                     res_if.irr_blue);
        end
      end
    end
  end

  function automatic logic [15:0] rand_comp();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(32768) - 16384);
  endfunction

  function automatic sample_t rand_sample(logic [1:0] op);
    return mk(op, rand_comp(), rand_comp(), rand_comp(), 8'($urandom), 8'($urandom),
              8'($urandom), $urandom);
  endfunction

  task automatic test_directed();
    send(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send(mk(OP_EVAL, 16384, 0, 0, 0, 0, 0, 0));
    send(mk(OP_ACCUM, 16384, 0, 0, 255, 255, 255, 32'hFFFF_FFFF));
    send(mk(OP_ACCUM, 0, 16384, 0, 255, 0, 128, 32'h8000_0000));
    send(mk(OP_ACCUM, 0, 0, 16384, 0, 255, 1, 32'h0000_0001));
    send(mk(OP_ACCUM, 16'(-16384), 0, 0, 17, 200, 3, 32'h1234_5678));
    send(mk(OP_ACCUM, 0, 16'(-16384), 16'(-16384), 0, 0, 0, 0));
    send(mk(OP_ACCUM, 9459, 9459, 9459, 255, 255, 255, 32'h0100_0000));
    send(mk(OP_ACCUM, 16'h8000, 16'h7FFF, 16'h8000, 90, 45, 10, 32'h4000_0000));
    send(mk(OP_EVAL, 0, 0, 16384, 0, 0, 0, 0));
    send(mk(OP_EVAL, 0, 0, 16'(-16384), 0, 0, 0, 0));
    send(mk(OP_EVAL, 16'(-16384), 0, 0, 0, 0, 0, 0));
    send(mk(OP_EVAL, 0, 16384, 0, 0, 0, 0, 0));
    send(mk(OP_EVAL, 16'h7FFF, 16'h8000, 16'h7FFF, 8'hFF, 8'hFF, 8'hFF, '1));
    send(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0));
    send(mk(OP_UNUSED, 16384, 16384, 16384, 255, 255, 255, '1));
    send(mk(OP_EVAL, 8000, 16'(-8000), 11000, 0, 0, 0, 0));
    send(mk(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 255, 255, 255, '1));
    send(mk(OP_EVAL, 8000, 16'(-8000), 11000, 0, 0, 0, 0));
  endtask

  task automatic test_saturation();
    send(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    repeat (40) send(mk(OP_ACCUM, 16'h7FFF, 16'h7FFF, 16'h7FFF, 255, 255, 255, '1));
    send(mk(OP_EVAL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0));
    send(mk(OP_EVAL, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0));
    repeat (80) send(mk(OP_ACCUM, 16'h8000, 16'h7FFF, 16'h8000, 255, 255, 255, '1));
    send(mk(OP_EVAL, 16'h7FFF, 16'h8000, 16'h7FFF, 0, 0, 0, 0));
    send(mk(OP_EVAL, 16384, 0, 0, 0, 0, 0, 0));
    send(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    hold_left = 400;
    repeat (4) send(rand_sample(OP_ACCUM));
    repeat (12) send(rand_sample(OP_EVAL));
    calm = 1'b0;
  endtask

  task automatic test_random();
    int cnt;
    int chunk;
    cnt = 0;
    chunk = 0;
    while (cnt < RANDOM_ITEMS) begin
      calm = (chunk >= 20 && chunk < 35);
      if ($urandom_range(4) == 0) begin
        send(rand_sample(OP_CLEAR));
        cnt++;
      end
      repeat ($urandom_range(10, 1)) begin
        send(rand_sample(OP_ACCUM));
        cnt++;
      end
      if ($urandom_range(19) == 0) send(rand_sample(OP_UNUSED));
      repeat ($urandom_range(3, 1)) begin
        send(rand_sample(OP_EVAL));
        cnt++;
      end
      if ($urandom_range(9) == 0) begin
        send(rand_sample(2'($urandom)));
        cnt++;
      end
      chunk++;
    end
    calm = 1'b0;
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.opcode = OP_CLEAR;
    req_if.dir_x = '0;
    req_if.dir_y = '0;
    req_if.dir_z = '0;
    req_if.pixel_red = '0;
    req_if.pixel_green = '0;
    req_if.pixel_blue = '0;
    req_if.sample_weight = '0;
    foreach (coef_store[i]) coef_store[i] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    test_backpressure();
    test_random();
    req_if.valid <= 1'b0;
    while (irr_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("covered %0d transfers in, %0d evaluations, %0d results checked",
             items_sent, evals_sent, results_seen);
    $display("clear, accumulate, evaluate, unused opcode, saturation and output stall");
    if (mismatches == 0) begin
      $display("sh_irradiance_project_and_eval test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("sh_irradiance_project_and_eval test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("sh_irradiance_project_and_eval test failed");
    $finish;
  end

endmodule
